@@ rtl/core/assert_macros.svh @@
// Assertion macros for the Ascon engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Concurrent assertion on the usual clk_i / rst_ni pair.
`define ASC_ASSERT(lbl, prop, msg) \
  `ASC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/core/asc_pkg.sv @@
// Types, constants and helper functions of the Ascon-AEAD128 engine.
`default_nettype none

package asc_pkg;

  typedef logic [4:0][63:0] state_t;

  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_AD     = 3'd1,
    OP_ENC    = 3'd2,
    OP_DEC    = 3'd3,
    OP_FINISH = 3'd4
  } op_e;

  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  localparam logic [63:0] ASCON_IV   = 64'h00001000808c0001;
  localparam logic [63:0] DOMAIN_BIT = 64'h8000000000000000;

  localparam logic [4:0] FULL_BYTES = 5'd16;

  // Round index of the first round for 12 and 8 rounds, and of the last one.
  localparam logic [3:0] RND_12   = 4'd0;
  localparam logic [3:0] RND_8    = 4'd4;
  localparam logic [3:0] RND_LAST = 4'd11;

  localparam logic [7:0] RC [12] = '{
    8'hf0, 8'he1, 8'hd2, 8'hc3, 8'hb4, 8'ha5,
    8'h96, 8'h87, 8'h78, 8'h69, 8'h5a, 8'h4b
  };

  // All bytes below n are set.
  function automatic logic [127:0] byte_mask(input logic [4:0] n);
    logic [127:0] m;
    for (int i = 0; i < 16; i++) begin
      m[8*i +: 8] = (5'(i) < n) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

  // A one in the low bit of byte n; nothing when the block is full.
  function automatic logic [127:0] pad_bit(input logic [4:0] n);
    logic [127:0] p;
    p = '0;
    for (int i = 0; i < 16; i++) begin
      p[8*i] = (5'(i) == n);
    end
    return p;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/asc_if.sv @@
// Valid/ready stream interfaces for the engine's input and result channels.
`default_nettype none

interface asc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [63:0] block_low;
  logic [63:0] block_high;
  logic [4:0]  byte_count;

  modport source (output valid, opcode, block_low, block_high, byte_count, input ready);
  modport sink   (input valid, opcode, block_low, block_high, byte_count, output ready);
endinterface

interface asc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_low;
  logic [63:0] data_high;
  logic        status;

  modport source (output valid, data_low, data_high, status, input ready);
  modport sink   (input valid, data_low, data_high, status, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ascon_aead128_engine.sv @@
// Ascon-AEAD128 engine: sequencer around one shared permutation round.
//
// The key is written through cfg_we_i / cfg_idx_i / cfg_data_i (index 0 holds
// key bytes 0 to 7, index 1 bytes 8 to 15); the user must write it only
// while the engine is idle, which the block itself does not enforce.
// Each input beat carries an opcode and a 16-byte block; each one gives
// exactly one result beat with data and a status bit (1 = sequence error,
// state untouched). A start beat loads key and nonce, associated data and
// text beats absorb one block, and a finish beat returns the tag.
// One round is computed per cycle in a single round unit. Start and finish
// run the full permutation, associated data and full text blocks the shorter
// one; empty associated data, partial text blocks and errors run none. A text
// or finish beat that closes non-empty associated data of a multiple of 16
// bytes first runs the shorter one on the padding block.
// The engine holds one item at a time: in_i.ready is high only while it is
// idle. A stalled result holds in the output register until out_o.ready,
// and no new beat is taken meanwhile.
// Reset clears the state, the key and the phase; only start is accepted
// without a sequence error afterwards.
`default_nettype none

module ascon_aead128_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  asc_in_if.sink      in_i,
  asc_out_if.source   out_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PERM, ST_DATA, ST_FIN, ST_POST, ST_OUT
  } st_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_AD    = 3'd2,
    PH_ENC   = 3'd3,
    PH_DEC   = 3'd4
  } phase_e;

  st_e             st_q, st_d, nxt_q, nxt_d;
  phase_e          phase_q, phase_d;
  asc_pkg::state_t s_q, s_d, rnd_out;
  logic [3:0]      rnd_q, rnd_d;
  logic [3:0]      po_q, po_d;
  logic            ps_q, ps_d, as_q, as_d, close_q, close_d;
  logic [63:0]     key_lo_q, key_lo_d, key_hi_q, key_hi_d;
  logic [127:0]    blk_q, blk_d, data_q, data_d;
  logic [4:0]      n_q, n_d;
  logic [2:0]      op_q, op_d;
  logic            status_q, status_d;

  logic [4:0]      n_in, off;
  logic [127:0]    blk_in, m_in, m, b, s01, s01_in, pad_fin;
  logic            err_now, close_now, pad_now;

  asc_round u_round (
    .state_i (s_q),
    .rnd_i   (rnd_q),
    .state_o (rnd_out)
  );

  always_comb begin
    n_in      = (in_i.byte_count > asc_pkg::FULL_BYTES) ? asc_pkg::FULL_BYTES
                                                        : in_i.byte_count;
    blk_in    = {in_i.block_high, in_i.block_low};
    m_in      = asc_pkg::byte_mask(n_in);
    s01       = {s_q[1], s_q[0]};
    s01_in    = s01 ^ (blk_in & m_in) ^ asc_pkg::pad_bit(n_in);
    m         = asc_pkg::byte_mask(n_q);
    b         = blk_q & m;
    off       = close_q ? 5'd0 : {1'b0, po_q};
    pad_fin   = asc_pkg::pad_bit(off);
    close_now = (phase_q == PH_START) || (phase_q == PH_AD);
    // Associated data of whole blocks still owes its padding block.
    pad_now   = (phase_q == PH_AD) && as_q && !ps_q;

    err_now = 1'b0;
    unique case (in_i.opcode)
      asc_pkg::OP_START:  err_now = 1'b0;
      asc_pkg::OP_AD:     err_now = !((phase_q == PH_START) ||
                                      ((phase_q == PH_AD) && !ps_q));
      asc_pkg::OP_ENC:    err_now = (phase_q == PH_DEC) || ((phase_q == PH_ENC) && ps_q);
      asc_pkg::OP_DEC:    err_now = (phase_q == PH_ENC) || ((phase_q == PH_DEC) && ps_q);
      asc_pkg::OP_FINISH: err_now = 1'b0;
      default:            err_now = 1'b1;
    endcase
    if ((phase_q == PH_IDLE) && (in_i.opcode != asc_pkg::OP_START)) begin
      err_now = 1'b1;
    end
  end

  always_comb begin
    st_d     = st_q;
    nxt_d    = nxt_q;
    phase_d  = phase_q;
    s_d      = s_q;
    rnd_d    = rnd_q;
    po_d     = po_q;
    ps_d     = ps_q;
    as_d     = as_q;
    close_d  = close_q;
    blk_d    = blk_q;
    n_d      = n_q;
    op_d     = op_q;
    data_d   = data_q;
    status_d = status_q;
    key_lo_d = key_lo_q;
    key_hi_d = key_hi_q;

    if (cfg_we_i) begin
      if (cfg_idx_i == asc_pkg::REG_KEY_LOW) begin
        key_lo_d = cfg_data_i;
      end else begin
        key_hi_d = cfg_data_i;
      end
    end

    unique case (st_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          blk_d    = blk_in;
          n_d      = n_in;
          op_d     = in_i.opcode;
          data_d   = '0;
          status_d = err_now;
          close_d  = close_now;
          st_d     = ST_OUT;
          if (!err_now) begin
            unique case (in_i.opcode)
              asc_pkg::OP_START: begin
                s_d     = {in_i.block_high, in_i.block_low, key_hi_q, key_lo_q,
                           asc_pkg::ASCON_IV};
                rnd_d   = asc_pkg::RND_12;
                nxt_d   = ST_POST;
                st_d    = ST_PERM;
                phase_d = PH_START;
                po_d    = 4'd0;
                ps_d    = 1'b0;
                as_d    = 1'b0;
              end
              asc_pkg::OP_AD: begin
                phase_d = PH_AD;
                if ((n_in == 5'd0) && !as_q) begin
                  // Empty associated data only closes the phase.
                  ps_d = 1'b1;
                end else begin
                  as_d  = as_q || (n_in != 5'd0);
                  ps_d  = (n_in != asc_pkg::FULL_BYTES);
                  s_d[0] = s01_in[63:0];
                  s_d[1] = s01_in[127:64];
                  rnd_d = asc_pkg::RND_8;
                  nxt_d = ST_OUT;
                  st_d  = ST_PERM;
                end
              end
              default: begin
                // Text and finish beats.
                if (pad_now) begin
                  s_d[0] = s_q[0] ^ 64'd1;
                  rnd_d  = asc_pkg::RND_8;
                  nxt_d  = (in_i.opcode == asc_pkg::OP_FINISH) ? ST_FIN : ST_DATA;
                  st_d   = ST_PERM;
                end else begin
                  st_d = (in_i.opcode == asc_pkg::OP_FINISH) ? ST_FIN : ST_DATA;
                end
              end
            endcase
          end
        end
      end
      ST_PERM: begin
        s_d   = rnd_out;
        rnd_d = rnd_q + 4'd1;
        if (rnd_q == asc_pkg::RND_LAST) begin
          st_d = nxt_q;
        end
      end
      ST_DATA: begin
        if (close_q) begin
          s_d[4] = s_q[4] ^ asc_pkg::DOMAIN_BIT;
          ps_d   = 1'b0;
          po_d   = 4'd0;
        end
        data_d = (s01 ^ b) & m;
        if (op_q == asc_pkg::OP_ENC) begin
          s_d[0]  = s_q[0] ^ b[63:0];
          s_d[1]  = s_q[1] ^ b[127:64];
          phase_d = PH_ENC;
        end else begin
          s_d[0]  = (s_q[0] & ~m[63:0]) | b[63:0];
          s_d[1]  = (s_q[1] & ~m[127:64]) | b[127:64];
          phase_d = PH_DEC;
        end
        if (n_q == asc_pkg::FULL_BYTES) begin
          rnd_d = asc_pkg::RND_8;
          nxt_d = ST_OUT;
          st_d  = ST_PERM;
        end else begin
          ps_d = 1'b1;
          po_d = n_q[3:0];
          st_d = ST_OUT;
        end
      end
      ST_FIN: begin
        s_d[0] = s_q[0] ^ pad_fin[63:0];
        s_d[1] = s_q[1] ^ pad_fin[127:64];
        s_d[2] = s_q[2] ^ key_lo_q;
        s_d[3] = s_q[3] ^ key_hi_q;
        if (close_q) begin
          s_d[4] = s_q[4] ^ asc_pkg::DOMAIN_BIT;
        end
        rnd_d = asc_pkg::RND_12;
        nxt_d = ST_POST;
        st_d  = ST_PERM;
      end
      ST_POST: begin
        s_d[3] = s_q[3] ^ key_lo_q;
        s_d[4] = s_q[4] ^ key_hi_q;
        if (op_q == asc_pkg::OP_FINISH) begin
          data_d  = {s_q[4] ^ key_hi_q, s_q[3] ^ key_lo_q};
          phase_d = PH_IDLE;
          po_d    = 4'd0;
          ps_d    = 1'b0;
          as_d    = 1'b0;
        end
        st_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_o.ready) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      nxt_q    <= ST_OUT;
      phase_q  <= PH_IDLE;
      s_q      <= '0;
      rnd_q    <= 4'd0;
      po_q     <= 4'd0;
      ps_q     <= 1'b0;
      as_q     <= 1'b0;
      close_q  <= 1'b0;
      blk_q    <= '0;
      n_q      <= 5'd0;
      op_q     <= asc_pkg::OP_START;
      data_q   <= '0;
      status_q <= 1'b0;
      key_lo_q <= '0;
      key_hi_q <= '0;
    end else begin
      st_q     <= st_d;
      nxt_q    <= nxt_d;
      phase_q  <= phase_d;
      s_q      <= s_d;
      rnd_q    <= rnd_d;
      po_q     <= po_d;
      ps_q     <= ps_d;
      as_q     <= as_d;
      close_q  <= close_d;
      blk_q    <= blk_d;
      n_q      <= n_d;
      op_q     <= op_d;
      data_q   <= data_d;
      status_q <= status_d;
      key_lo_q <= key_lo_d;
      key_hi_q <= key_hi_d;
    end
  end

  assign in_i.ready      = (st_q == ST_IDLE);
  assign out_o.valid     = (st_q == ST_OUT);
  assign out_o.data_low  = data_q[63:0];
  assign out_o.data_high = data_q[127:64];
  assign out_o.status    = status_q;

`include "assert_macros.svh"

  `ASC_ASSERT(a_one_item, in_i.ready |-> !out_o.valid, "input taken while a result is pending")
  `ASC_ASSERT(a_err_zero,
              (out_o.valid && out_o.status) |->
                (out_o.data_low == 64'd0 && out_o.data_high == 64'd0),
              "error result carries data")
  `ASC_ASSERT(a_rnd_step,
              (st_q == ST_PERM && rnd_q != asc_pkg::RND_LAST) |=>
                (st_q == ST_PERM && rnd_q == $past(rnd_q) + 4'd1),
              "round sequence broken")

endmodule

`default_nettype wire

@@ rtl/core/asc_round.sv @@
// One Ascon permutation round: constant addition, S-box layer, linear layer.
`default_nettype none

module asc_round (
  input  asc_pkg::state_t state_i,
  input  logic [3:0]      rnd_i,
  output asc_pkg::state_t state_o
);

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  logic [63:0] s2;
  logic [63:0] x0, x1, x2, x3, x4;
  logic [63:0] t0, t1, t2, t3, t4;
  logic [63:0] u0, u1, u2, u3;

  always_comb begin
    s2 = state_i[2] ^ {56'd0, asc_pkg::RC[rnd_i]};
    x0 = state_i[0] ^ state_i[4];
    x4 = state_i[4] ^ state_i[3];
    x2 = s2 ^ state_i[1];
    x1 = state_i[1];
    x3 = state_i[3];
    t0 = x0 ^ (~x1 & x2);
    t1 = x1 ^ (~x2 & x3);
    t2 = x2 ^ (~x3 & x4);
    t3 = x3 ^ (~x4 & x0);
    t4 = x4 ^ (~x0 & x1);
    u1 = t1 ^ t0;
    u3 = t3 ^ t2;
    u0 = t0 ^ t4;
    u2 = ~t2;
    state_o[0] = u0 ^ rotr(u0, 19) ^ rotr(u0, 28);
    state_o[1] = u1 ^ rotr(u1, 61) ^ rotr(u1, 39);
    state_o[2] = u2 ^ rotr(u2, 1)  ^ rotr(u2, 6);
    state_o[3] = u3 ^ rotr(u3, 10) ^ rotr(u3, 17);
    state_o[4] = t4 ^ rotr(t4, 7)  ^ rotr(t4, 41);
  end

endmodule

`default_nettype wire

@@ test/aead_checker.sv @@
// Checker for the Ascon-AEAD128 engine: predicts each result beat and compares it.
`timescale 1ns / 100ps

module aead_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  asc_in_if           in_mon,
  asc_out_if          out_mon,
  output int          mismatches_o,
  output int          owed_o
);

  localparam logic [63:0] INIT_WORD  = 64'h00001000808c0001;
  localparam logic [63:0] DOMAIN_SEP = 64'h8000000000000000;

  typedef logic [63:0] lane_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_STARTED,
    PH_ASSOC,
    PH_ENC,
    PH_DEC
  } phase_e;

  typedef struct packed {
    lane_t data_low;
    lane_t data_high;
    logic  status;
  } aead_out_t;

  logic [4:0][63:0] st;
  lane_t            key_lo;
  lane_t            key_hi;
  phase_e           phase;
  logic [3:0]       part_off;
  logic             part_seen;
  logic             assoc_seen;
  aead_out_t        owed_results[$];
  aead_out_t        want;

  function automatic lane_t ror(lane_t x, int sh);
    return (x >> sh) | (x << (64 - sh));
  endfunction

  function automatic logic [127:0] keep_mask(logic [4:0] n);
    return (n >= 5'd16) ? {128{1'b1}} : ((128'd1 << (8 * n)) - 128'd1);
  endfunction

  // The last rounds of the twelve-round schedule, on the checker's own state.
  function automatic void run_rounds(int count);
    lane_t x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
    for (int r = 12 - count; r < 12; r++) begin
      st[2] = st[2] ^ {56'd0, 4'(15 - r), 4'(r)};
      x0 = st[0] ^ st[4];
      x4 = st[4] ^ st[3];
      x2 = st[2] ^ st[1];
      x1 = st[1];
      x3 = st[3];
      t0 = x0 ^ (~x1 & x2);
      t1 = x1 ^ (~x2 & x3);
      t2 = x2 ^ (~x3 & x4);
      t3 = x3 ^ (~x4 & x0);
      t4 = x4 ^ (~x0 & x1);
      t1 = t1 ^ t0;
      t3 = t3 ^ t2;
      t0 = t0 ^ t4;
      t2 = ~t2;
      st[0] = t0 ^ ror(t0, 19) ^ ror(t0, 28);
      st[1] = t1 ^ ror(t1, 61) ^ ror(t1, 39);
      st[2] = t2 ^ ror(t2, 1) ^ ror(t2, 6);
      st[3] = t3 ^ ror(t3, 10) ^ ror(t3, 17);
      st[4] = t4 ^ ror(t4, 7) ^ ror(t4, 41);
    end
  endfunction

  // Leaving associated data: a full last block still owes its padding block.
  function automatic void close_assoc();
    if (phase == PH_ASSOC && assoc_seen && !part_seen) begin
      st[0] = st[0] ^ 64'd1;
      run_rounds(8);
    end
    st[4] = st[4] ^ DOMAIN_SEP;
    part_seen = 1'b0;
    part_off = '0;
  endfunction

  function automatic aead_out_t aead_step(logic [2:0] op, lane_t b0, lane_t b1,
                                          logic [4:0] cnt);
    logic [4:0]   n;
    logic [127:0] m;
    logic [127:0] blk;
    logic [127:0] rate;
    logic         bad;
    aead_out_t    res;
    n = (cnt > 5'd16) ? 5'd16 : cnt;
    res = '0;
    bad = 1'b0;
    if (op == asc_pkg::OP_START) begin
      st = {b1, b0, key_hi, key_lo, INIT_WORD};
      run_rounds(12);
      st[3] = st[3] ^ key_lo;
      st[4] = st[4] ^ key_hi;
      phase = PH_STARTED;
      part_off = '0;
      part_seen = 1'b0;
      assoc_seen = 1'b0;
      return res;
    end
    if (op > asc_pkg::OP_FINISH || phase == PH_IDLE) begin
      bad = 1'b1;
    end else if (op == asc_pkg::OP_AD) begin
      bad = !(phase == PH_STARTED || (phase == PH_ASSOC && !part_seen));
    end else if (op == asc_pkg::OP_ENC) begin
      bad = (phase == PH_DEC) || (phase == PH_ENC && part_seen);
    end else if (op == asc_pkg::OP_DEC) begin
      bad = (phase == PH_ENC) || (phase == PH_DEC && part_seen);
    end
    if (bad) begin
      res.status = 1'b1;
      return res;
    end
    m = keep_mask(n);
    blk = {b1, b0} & m;
    if (op == asc_pkg::OP_AD) begin
      phase = PH_ASSOC;
      // An empty block before any associated byte only closes the phase.
      if (n == 5'd0 && !assoc_seen) begin
        part_seen = 1'b1;
        return res;
      end
      assoc_seen = assoc_seen || (n != 5'd0);
      rate = st[1:0] ^ blk;
      if (n < 5'd16) begin
        rate = rate ^ (128'd1 << (8 * n));
        part_seen = 1'b1;
      end
      st[1:0] = rate;
      run_rounds(8);
      return res;
    end
    if (phase == PH_STARTED || phase == PH_ASSOC) begin
      close_assoc();
    end
    if (op == asc_pkg::OP_ENC || op == asc_pkg::OP_DEC) begin
      rate = st[1:0];
      if (op == asc_pkg::OP_ENC) begin
        rate = rate ^ blk;
        {res.data_high, res.data_low} = rate & m;
        phase = PH_ENC;
      end else begin
        {res.data_high, res.data_low} = (rate ^ blk) & m;
        rate = (rate & ~m) | blk;
        phase = PH_DEC;
      end
      st[1:0] = rate;
      if (n == 5'd16) begin
        run_rounds(8);
      end else begin
        part_seen = 1'b1;
        part_off = n[3:0];
      end
      return res;
    end
    st[1:0] = st[1:0] ^ (128'd1 << (8 * part_off));
    st[2] = st[2] ^ key_lo;
    st[3] = st[3] ^ key_hi;
    run_rounds(12);
    st[3] = st[3] ^ key_lo;
    st[4] = st[4] ^ key_hi;
    res.data_low = st[3];
    res.data_high = st[4];
    phase = PH_IDLE;
    part_off = '0;
    part_seen = 1'b0;
    assoc_seen = 1'b0;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo = '0;
      key_hi = '0;
      st = '0;
      phase = PH_IDLE;
      part_off = '0;
      part_seen = 1'b0;
      assoc_seen = 1'b0;
      owed_results.delete();
      mismatches_o = 0;
      owed_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == asc_pkg::REG_KEY_LOW) begin
          key_lo = cfg_data_i;
        end else if (cfg_idx_i == asc_pkg::REG_KEY_HIGH) begin
          key_hi = cfg_data_i;
        end
      end
      // A new beat goes behind any older result, so push before popping.
      if (in_mon.valid && in_mon.ready) begin
        owed_results.push_back(aead_step(in_mon.opcode, in_mon.block_low,
                                         in_mon.block_high, in_mon.byte_count));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (owed_results.size() == 0) begin
          $error("result beat with no expected result");
          mismatches_o++;
        end else begin
          want = owed_results.pop_front();
          if (out_mon.data_low !== want.data_low) begin
            $error("data_low: expected %h, got %h", want.data_low, out_mon.data_low);
            mismatches_o++;
          end
          if (out_mon.data_high !== want.data_high) begin
            $error("data_high: expected %h, got %h", want.data_high, out_mon.data_high);
            mismatches_o++;
          end
          if (out_mon.status !== want.status) begin
            $error("status: expected %b, got %b", want.status, out_mon.status);
            mismatches_o++;
          end
        end
      end
      owed_o = owed_results.size();
    end
  end

endmodule

@@ test/testbench.sv @@
// Top of the Ascon-AEAD128 engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;

  localparam int          ITEM_TARGET  = 1300;
  localparam int          PHASES       = 6;
  localparam int          LONG_HOLD    = 400;
  localparam int          STALL_LIMIT  = 4000;
  localparam int          DRAIN_CYCLES = 40;
  localparam logic [2:0]  OP_UNUSED    = 3'd7;
  localparam logic [63:0] ONES         = {64{1'b1}};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [63:0] cfg_data_i;
  int          mismatches;
  int          owed;
  int          items_sent;
  int          quiet_cycles = 0;
  bit          idling_on;
  bit          hold_long;

  asc_in_if  in_if ();
  asc_out_if out_if ();

  ascon_aead128_engine dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  aead_checker aead_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .mismatches_o (mismatches),
    .owed_o       (owed)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // Mostly a plain full block; now and then a count above 16.
  function automatic logic [4:0] full_count();
    return ($urandom_range(0, 7) == 0) ? 5'($urandom_range(17, 31)) : 5'd16;
  endfunction

  // Offers one beat and returns at the edge where it is taken; valid stays up.
  task automatic send_beat(input logic [2:0] op, input logic [63:0] lo,
                           input logic [63:0] hi, input logic [4:0] cnt);
    int gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.opcode     <= op;
    in_if.block_low  <= lo;
    in_if.block_high <= hi;
    in_if.byte_count <= cnt;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  // A beat of a message, sometimes preceded by a stray beat of any kind.
  task automatic message_beat(input logic [2:0] op, input logic [63:0] lo,
                              input logic [63:0] hi, input logic [4:0] cnt);
    if ($urandom_range(0, 29) == 0) begin
      send_beat(3'($urandom_range(0, 7)), rnd64(), rnd64(), 5'($urandom_range(0, 31)));
    end
    send_beat(op, lo, hi, cnt);
  endtask

  task automatic send_message();
    int         n_full;
    logic [2:0] text_op;
    message_beat(asc_pkg::OP_START, rnd64(), rnd64(), 5'($urandom_range(0, 31)));
    if ($urandom_range(0, 9) == 0) begin
      message_beat(asc_pkg::OP_AD, rnd64(), rnd64(), 5'd0);
    end else begin
      n_full = $urandom_range(0, 3);
      repeat (n_full) message_beat(asc_pkg::OP_AD, rnd64(), rnd64(), full_count());
      if ($urandom_range(0, 1) == 1) begin
        message_beat(asc_pkg::OP_AD, rnd64(), rnd64(), 5'($urandom_range(0, 15)));
      end
    end
    text_op = ($urandom_range(0, 1) == 1) ? asc_pkg::OP_DEC : asc_pkg::OP_ENC;
    n_full = $urandom_range(0, 3);
    repeat (n_full) message_beat(text_op, rnd64(), rnd64(), full_count());
    if ($urandom_range(0, 1) == 1) begin
      message_beat(text_op, rnd64(), rnd64(), 5'($urandom_range(0, 15)));
    end
    // Occasionally the message is abandoned and the next start restarts.
    if ($urandom_range(0, 15) != 0) begin
      message_beat(asc_pkg::OP_FINISH, rnd64(), rnd64(), 5'($urandom_range(0, 31)));
    end
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (owed != 0);
  endtask

  task automatic load_key(input logic [63:0] lo, input logic [63:0] hi);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= asc_pkg::REG_KEY_LOW;
    cfg_data_i <= lo;
    @(posedge clk_i);
    cfg_idx_i  <= asc_pkg::REG_KEY_HIGH;
    cfg_data_i <= hi;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always begin : result_sink
    int stall;
    @(posedge clk_i);
    if (hold_long) begin
      hold_long = 1'b0;
      out_if.ready <= 1'b0;
      repeat (LONG_HOLD) @(posedge clk_i);
      out_if.ready <= 1'b1;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      stall = $urandom_range(1, 15);
      out_if.ready <= 1'b0;
      repeat (stall) @(posedge clk_i);
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = asc_pkg::REG_KEY_LOW;
    cfg_data_i       = '0;
    in_if.valid      = 1'b0;
    in_if.opcode     = asc_pkg::OP_START;
    in_if.block_low  = '0;
    in_if.block_high = '0;
    in_if.byte_count = '0;
    out_if.ready     = 1'b0;
    idling_on        = 1'b1;
    hold_long        = 1'b0;
    items_sent       = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    load_key(rnd64(), rnd64());

    // Nothing but start is taken without a sequence error while idle.
    send_beat(asc_pkg::OP_AD, rnd64(), rnd64(), 5'd16);
    send_beat(asc_pkg::OP_FINISH, '0, '0, 5'd0);
    send_beat(OP_UNUSED, ONES, ONES, 5'd31);
    // Empty associated data closes the phase, so more associated data is refused.
    send_beat(asc_pkg::OP_START, ONES, ONES, 5'd31);
    send_beat(asc_pkg::OP_AD, '0, '0, 5'd0);
    send_beat(asc_pkg::OP_AD, ONES, ONES, 5'd16);
    send_beat(asc_pkg::OP_ENC, ONES, ONES, 5'd16);
    send_beat(asc_pkg::OP_ENC, rnd64(), rnd64(), 5'd0);
    send_beat(asc_pkg::OP_ENC, rnd64(), rnd64(), 5'd16);
    send_beat(asc_pkg::OP_AD, rnd64(), rnd64(), 5'd16);
    send_beat(asc_pkg::OP_FINISH, rnd64(), rnd64(), 5'd16);
    // Associated data of whole blocks owes a padding block; mixing directions fails.
    send_beat(asc_pkg::OP_START, '0, '0, 5'd0);
    send_beat(asc_pkg::OP_AD, ONES, ONES, 5'd16);
    send_beat(asc_pkg::OP_AD, rnd64(), rnd64(), 5'd20);
    send_beat(asc_pkg::OP_DEC, ONES, '0, 5'd16);
    send_beat(asc_pkg::OP_ENC, rnd64(), rnd64(), 5'd16);
    send_beat(asc_pkg::OP_DEC, rnd64(), rnd64(), 5'd9);
    send_beat(asc_pkg::OP_FINISH, '0, '0, 5'd0);
    // Partial associated data straight to the tag, an empty message, a restart.
    send_beat(asc_pkg::OP_START, rnd64(), rnd64(), 5'd16);
    send_beat(asc_pkg::OP_AD, ONES, ONES, 5'd7);
    send_beat(asc_pkg::OP_FINISH, '0, '0, 5'd0);
    send_beat(asc_pkg::OP_START, rnd64(), rnd64(), 5'd16);
    send_beat(asc_pkg::OP_FINISH, '0, '0, 5'd0);
    send_beat(asc_pkg::OP_START, rnd64(), rnd64(), 5'd16);
    send_beat(asc_pkg::OP_AD, rnd64(), rnd64(), 5'd15);
    send_beat(asc_pkg::OP_START, rnd64(), rnd64(), 5'd16);
    send_beat(asc_pkg::OP_DEC, ONES, ONES, 5'd8);
    send_beat(asc_pkg::OP_FINISH, '0, '0, 5'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      unique case (ph)
        0: begin
          load_key('0, '0);
        end
        1: begin
          load_key(ONES, ONES);
        end
        2: begin
          load_key(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        end
        default: begin
          load_key(rnd64(), rnd64());
        end
      endcase
      idling_on = (ph != PHASES - 1);
      // The sink holds off for a long stretch while messages keep coming.
      hold_long = (ph == 2);
      while (items_sent < ITEM_TARGET * (ph + 1) / PHASES) begin
        send_message();
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && owed == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/asc_pkg.sv
rtl/core/asc_if.sv
rtl/core/asc_round.sv
rtl/core/ascon_aead128_engine.sv
test/aead_checker.sv
test/testbench.sv
